// ----- hdl/vcr_pkg.sv -----
// ----------------------------------------------------------------------------
// vcr_pkg
// shared types, codes and helpers of the video controller register block
// ----------------------------------------------------------------------------
package vcr_pkg;

  localparam int unsigned VramAddrW = 16;
  localparam int unsigned PramAddrW = 10;
  localparam int unsigned DataW     = 8;

  typedef enum logic [3:0] {
    OP_VRAM_RD = 4'd0,
    OP_VRAM_WR = 4'd1,
    OP_PAL_RD  = 4'd2,
    OP_PAL_WR  = 4'd3,
    OP_CTRL_WR = 4'd4,
    OP_HPOS_RD = 4'd5,
    OP_VPOS_RD = 4'd6,
    OP_IRQ_CLR = 4'd7,
    OP_VBLANK  = 4'd8,
    OP_BEAM    = 4'd9,
    OP_COLLIDE = 4'd10
  } vcr_op_e;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_VRAM   = 2'd1,
    SRC_PRAM   = 2'd2,
    SRC_DIRECT = 2'd3
  } vcr_src_e;

  typedef struct packed {
    logic [3:0] opcode;
    logic [8:0] offset;
    logic [7:0] write_data;
    logic [7:0] row_select;
    logic [8:0] beam_line;
    logic [8:0] beam_x;
  } vcr_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       firq_line;
    logic [3:0] rom_bank;
    logic       visible_bank;
    logic       color_valid;
    logic [7:0] color_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } vcr_result_t;

  // memory requests issued when a word is taken
  typedef struct packed {
    logic                 vram_we;
    logic [VramAddrW-1:0] vram_addr;
    logic                 pram_we;
    logic [PramAddrW-1:0] pram_waddr;
    logic [PramAddrW-1:0] pram_raddr;
    logic [DataW-1:0]     wdata;
  } vcr_mem_req_t;

  // decoded word waiting for its memory data
  typedef struct packed {
    logic       valid;
    vcr_src_e   src;
    logic [7:0] direct_data;
    logic       color_valid;
    logic [7:0] color_index;
    logic [7:0] write_data;
    logic       high_written;
    logic       firq_line;
    logic [3:0] rom_bank;
    logic       visible_bank;
  } vcr_stage_t;

  function automatic logic [7:0] expand5(input logic [4:0] c);
    expand5 = {c, c[4:2]};
  endfunction

endpackage

// ----- hdl/video_controller_registers.sv -----
// ----------------------------------------------------------------------------
// video_controller_registers
// register side of a video board: video memory, two-bank palette, control
// register and fast interrupt logic
// ----------------------------------------------------------------------------
// usage
//   a command word (cmd_i) is taken at a rising edge with start high and
//   busy low; one result word follows on result_o, marked by result_valid_o
//   for exactly one cycle; the edge that takes the command registers the
//   decoded word and the memory read data, the next edge registers the result
//   throughput is one command per cycle while busy is low; each memory has
//   one read and one write per cycle, writes land at the taking edge, so a
//   following read sees them
//   after reset busy stays high while a clearing pass writes zero to every
//   video memory byte, and the palette with it
//   the receiver cannot stall; a result is gone after its cycle
// ----------------------------------------------------------------------------
module video_controller_registers
  import vcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  vcr_cmd_t    cmd_i,
  output logic        result_valid_o,
  output vcr_result_t result_o
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } vcr_state_e;

  vcr_state_e state_q, state_d;
  logic [VramAddrW-1:0] clr_addr_q, clr_addr_d;

  logic         accept;
  logic         clearing;
  vcr_mem_req_t req;
  vcr_stage_t   stage;

  logic                 vram_we;
  logic [VramAddrW-1:0] vram_addr;
  logic                 pram_we;
  logic [PramAddrW-1:0] pram_waddr;
  logic [DataW-1:0]     vram_wdata;
  logic [DataW-1:0]     pram_wdata;
  logic [DataW-1:0]     vram_rdata;
  logic [DataW-1:0]     pram_rdata;

  logic [15:0]  color_word;
  vcr_result_t  result_d, result_q;
  logic         valid_q;

  assign clearing = (state_q == ST_CLEAR);
  assign busy     = clearing;
  assign accept   = start & ~busy;

  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + VramAddrW'(1);
        if (&clr_addr_q) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: ;
      default: state_d = ST_CLEAR;
    endcase
  end

  vcr_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i),
    .req_o    (req),
    .stage_o  (stage)
  );

  assign vram_we    = clearing | req.vram_we;
  assign vram_addr  = clearing ? clr_addr_q : req.vram_addr;
  assign vram_wdata = clearing ? '0 : req.wdata;
  assign pram_we    = clearing | req.pram_we;
  assign pram_waddr = clearing ? clr_addr_q[PramAddrW-1:0] : req.pram_waddr;
  assign pram_wdata = clearing ? '0 : req.wdata;

  vcr_vram u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .addr_i  (vram_addr),
    .wdata_i (vram_wdata),
    .rdata_o (vram_rdata)
  );

  vcr_pram u_pram (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .waddr_i (pram_waddr),
    .wdata_i (pram_wdata),
    .raddr_i (req.pram_raddr),
    .rdata_o (pram_rdata)
  );

  // even byte of the pair is the high byte
  assign color_word = stage.high_written ? {stage.write_data, pram_rdata}
                                         : {pram_rdata, stage.write_data};

  always_comb begin
    result_d              = '0;
    result_d.firq_line    = stage.firq_line;
    result_d.rom_bank     = stage.rom_bank;
    result_d.visible_bank = stage.visible_bank;
    case (stage.src)
      SRC_VRAM:   result_d.read_data = vram_rdata;
      SRC_PRAM:   result_d.read_data = pram_rdata;
      SRC_DIRECT: result_d.read_data = stage.direct_data;
      default:    result_d.read_data = '0;
    endcase
    if (stage.color_valid) begin
      result_d.color_valid = 1'b1;
      result_d.color_index = stage.color_index;
      result_d.red         = expand5(color_word[14:10]);
      result_d.green       = expand5(color_word[9:5]);
      result_d.blue        = expand5(color_word[4:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      valid_q    <= stage.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

// ----- hdl/vcr_vram.sv -----
// ----------------------------------------------------------------------------
// vcr_vram
// video memory, two pixels per byte, one access per cycle
// ----------------------------------------------------------------------------
module vcr_vram
  import vcr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [VramAddrW-1:0] addr_i,
  input  logic [DataW-1:0]     wdata_i,
  output logic [DataW-1:0]     rdata_o
);

  logic [DataW-1:0] mem_q [2**VramAddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/vcr_pram.sv -----
// ----------------------------------------------------------------------------
// vcr_pram
// palette memory, two banks of 512 bytes, one write and one read port
// ----------------------------------------------------------------------------
module vcr_pram
  import vcr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [PramAddrW-1:0] waddr_i,
  input  logic [DataW-1:0]     wdata_i,
  input  logic [PramAddrW-1:0] raddr_i,
  output logic [DataW-1:0]     rdata_o
);

  logic [DataW-1:0] mem_q [2**PramAddrW];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/vcr_regs.sv -----
// ----------------------------------------------------------------------------
// vcr_regs
// command decode, control and interrupt registers, memory requests
// ----------------------------------------------------------------------------
module vcr_regs
  import vcr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  vcr_cmd_t     cmd_i,
  output vcr_mem_req_t req_o,
  output vcr_stage_t   stage_o
);

  logic       irq_en_q, irq_en_d;
  logic       irq_sel_q, irq_sel_d;
  logic       acc_bank_q, acc_bank_d;
  logic       shown_bank_q, shown_bank_d;
  logic [3:0] cpu_bank_q, cpu_bank_d;
  logic       vblank_q, vblank_d;
  logic       beam_q, beam_d;
  logic [7:0] latch_q, latch_d;

  logic [9:0] x_plus;
  logic [8:0] x_half;
  logic [7:0] x_conv;

  vcr_stage_t stage_d, stage_q;

  assign x_plus = {1'b0, cmd_i.beam_x} + 10'd1;
  assign x_half = x_plus[9:1];
  assign x_conv = (x_half[7:0] + 8'd3) ^ 8'h02;

  always_comb begin
    irq_en_d     = irq_en_q;
    irq_sel_d    = irq_sel_q;
    acc_bank_d   = acc_bank_q;
    shown_bank_d = shown_bank_q;
    cpu_bank_d   = cpu_bank_q;
    vblank_d     = vblank_q;
    beam_d       = beam_q;
    latch_d      = latch_q;

    req_o.vram_we    = 1'b0;
    req_o.vram_addr  = {cmd_i.row_select, 8'h00} + {7'd0, cmd_i.offset};
    req_o.pram_we    = 1'b0;
    req_o.pram_waddr = {acc_bank_q, cmd_i.offset};
    req_o.pram_raddr = {acc_bank_q, cmd_i.offset};
    req_o.wdata      = cmd_i.write_data;

    stage_d              = '0;
    stage_d.valid        = accept_i;
    stage_d.src          = SRC_NONE;
    stage_d.color_index  = cmd_i.offset[8:1];
    stage_d.write_data   = cmd_i.write_data;
    stage_d.high_written = ~cmd_i.offset[0];

    unique case (cmd_i.opcode)
      OP_VRAM_RD: stage_d.src = SRC_VRAM;
      OP_VRAM_WR: req_o.vram_we = accept_i;
      OP_PAL_RD:  stage_d.src = SRC_PRAM;
      OP_PAL_WR: begin
        req_o.pram_we       = accept_i;
        req_o.pram_raddr    = {acc_bank_q, cmd_i.offset[8:1], ~cmd_i.offset[0]};
        stage_d.color_valid = (acc_bank_q == shown_bank_q);
      end
      OP_CTRL_WR: begin
        cpu_bank_d   = cmd_i.write_data[7:4];
        irq_en_d     = cmd_i.write_data[3];
        irq_sel_d    = cmd_i.write_data[2];
        acc_bank_d   = cmd_i.write_data[1];
        shown_bank_d = cmd_i.write_data[0];
      end
      OP_HPOS_RD: begin
        beam_d              = 1'b0;
        stage_d.src         = SRC_DIRECT;
        stage_d.direct_data = latch_q;
      end
      OP_VPOS_RD: begin
        stage_d.src         = SRC_DIRECT;
        stage_d.direct_data = cmd_i.beam_line[8] ? 8'hff : cmd_i.beam_line[7:0];
      end
      OP_IRQ_CLR: vblank_d = 1'b0;
      OP_VBLANK:  vblank_d = 1'b1;
      OP_BEAM: begin
        if (irq_sel_q && irq_en_q) begin
          beam_d = 1'b1;
        end
        latch_d = x_conv;
      end
      OP_COLLIDE: begin
        if (!irq_sel_q && irq_en_q) begin
          beam_d = 1'b1;
        end
        latch_d = x_conv;
      end
      default: ;
    endcase

    stage_d.firq_line    = vblank_d | (irq_en_d & beam_d);
    stage_d.rom_bank     = cpu_bank_d;
    stage_d.visible_bank = shown_bank_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q     <= 1'b0;
      irq_sel_q    <= 1'b0;
      acc_bank_q   <= 1'b0;
      shown_bank_q <= 1'b0;
      cpu_bank_q   <= '0;
      vblank_q     <= 1'b0;
      beam_q       <= 1'b0;
      latch_q      <= '0;
      stage_q      <= '0;
    end else begin
      stage_q <= stage_d;
      if (accept_i) begin
        irq_en_q     <= irq_en_d;
        irq_sel_q    <= irq_sel_d;
        acc_bank_q   <= acc_bank_d;
        shown_bank_q <= shown_bank_d;
        cpu_bank_q   <= cpu_bank_d;
        vblank_q     <= vblank_d;
        beam_q       <= beam_d;
        latch_q      <= latch_d;
      end
    end
  end

  assign stage_o = stage_q;

endmodule

// ----- hdl/vcr_checker.sv -----
// ----------------------------------------------------------------------------
// vcr_checker
// port-level checks of the video controller register block
// ----------------------------------------------------------------------------
module vcr_checker
  import vcr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input vcr_cmd_t    cmd_i,
  input logic        result_valid_o,
  input vcr_result_t result_o
);

  logic accept;
  assign accept = start & ~busy;

  a_result_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 result_valid_o
  ) else $error("taken word produced no result");

  a_no_stray_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(accept, 2)
  ) else $error("result without a taken word");

  a_color_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.color_valid) |->
      (result_o.color_index == 8'd0 && result_o.red == 8'd0 &&
       result_o.green == 8'd0 && result_o.blue == 8'd0)
  ) else $error("color fields set without color_valid");

  a_ctrl_bank: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $past(accept && cmd_i.opcode == OP_CTRL_WR, 2) |->
      (result_o.rom_bank == $past(cmd_i.write_data[7:4], 2) &&
       result_o.visible_bank == $past(cmd_i.write_data[0], 2))
  ) else $error("control write not reflected");

  a_write_reads_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $past(accept && cmd_i.opcode == OP_VRAM_WR, 2) |-> result_o.read_data == 8'd0
  ) else $error("write returned read data");

endmodule

bind video_controller_registers vcr_checker u_vcr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// ----- verif/vcr_result_checker.sv -----
// ----------------------------------------------------------------------------
// vcr_result_checker
// watches the command and result channels of the video controller register
// block, keeps its own copy of video memory, palette and control state,
// predicts one result word per accepted command and compares it field by
// field with the oldest prediction
// ----------------------------------------------------------------------------
module vcr_result_checker
  import vcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  vcr_cmd_t    cmd_i,
  input  logic        res_valid_i,
  input  vcr_result_t res_i,
  output int          errors_o,
  output int          pending_o,
  output int          colors_o
);

  logic [7:0] vram_model [65536];
  logic [7:0] pal_model [1024];
  logic       irq_en;
  logic       irq_sel;
  logic       acc_bank;
  logic       shown_bank;
  logic [3:0] cpu_bank;
  logic       vblank_pend;
  logic       beam_pend;
  logic [7:0] x_latch;

  vcr_result_t expected_results [$];

  function automatic logic [7:0] stretch5(input logic [4:0] c);
    logic [7:0] w;
    w = {3'b000, c};
    return (w << 3) | (w >> 2);
  endfunction

  // converted beam x, wraps to 8 bits
  function automatic logic [7:0] beam_to_pos(input logic [8:0] x);
    logic [9:0] sum;
    logic [9:0] t;
    sum = {1'b0, x} + 10'd1;
    t = {1'b0, sum[9:1]} + 10'd3;
    return t[7:0] ^ 8'h02;
  endfunction

  task automatic predict_result(input vcr_cmd_t c, output vcr_result_t r);
    logic [15:0] vaddr;
    logic [9:0]  paddr;
    logic [9:0]  pair;
    logic [15:0] rgb;
    vaddr = {c.row_select, 8'h00} + {7'd0, c.offset};
    paddr = {acc_bank, c.offset};
    r = '0;
    case (c.opcode)
      OP_VRAM_RD: r.read_data = vram_model[vaddr];
      OP_VRAM_WR: vram_model[vaddr] = c.write_data;
      OP_PAL_RD:  r.read_data = pal_model[paddr];
      OP_PAL_WR: begin
        pal_model[paddr] = c.write_data;
        if (acc_bank == shown_bank) begin
          pair = {shown_bank, c.offset[8:1], 1'b0};
          rgb = {pal_model[pair], pal_model[pair | 10'd1]};
          r.color_valid = 1'b1;
          r.color_index = c.offset[8:1];
          r.red = stretch5(rgb[14:10]);
          r.green = stretch5(rgb[9:5]);
          r.blue = stretch5(rgb[4:0]);
        end
      end
      OP_CTRL_WR: {cpu_bank, irq_en, irq_sel, acc_bank, shown_bank} = c.write_data;
      OP_HPOS_RD: begin
        beam_pend = 1'b0;
        r.read_data = x_latch;
      end
      OP_VPOS_RD: r.read_data = (c.beam_line < 9'd255) ? c.beam_line[7:0] : 8'hff;
      OP_IRQ_CLR: vblank_pend = 1'b0;
      OP_VBLANK:  vblank_pend = 1'b1;
      OP_BEAM: begin
        if (irq_sel && irq_en) beam_pend = 1'b1;
        x_latch = beam_to_pos(c.beam_x);
      end
      OP_COLLIDE: begin
        if (!irq_sel && irq_en) beam_pend = 1'b1;
        x_latch = beam_to_pos(c.beam_x);
      end
      default: ;
    endcase
    r.firq_line = vblank_pend | (irq_en & beam_pend);
    r.rom_bank = cpu_bank;
    r.visible_bank = shown_bank;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors_o++;
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vcr_result_t want;
    if (!rst_ni) begin
      for (int a = 0; a < 65536; a++) vram_model[a] = '0;
      for (int a = 0; a < 1024; a++) pal_model[a] = '0;
      {irq_en, irq_sel, acc_bank, shown_bank, vblank_pend, beam_pend} = '0;
      cpu_bank = '0;
      x_latch = '0;
      expected_results.delete();
      errors_o = 0;
      pending_o = 0;
      colors_o = 0;
    end else begin
      // result first: a word taken at this edge cannot answer yet
      if (res_valid_i) begin
        if (expected_results.size() == 0) begin
          errors_o++;
          $display("%0t unexpected result word, actual %h", $time, res_i);
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.read_data, res_i.read_data);
          check_field("firq_line", want.firq_line, res_i.firq_line);
          check_field("rom_bank", want.rom_bank, res_i.rom_bank);
          check_field("visible_bank", want.visible_bank, res_i.visible_bank);
          check_field("color_valid", want.color_valid, res_i.color_valid);
          check_field("color_index", want.color_index, res_i.color_index);
          check_field("red", want.red, res_i.red);
          check_field("green", want.green, res_i.green);
          check_field("blue", want.blue, res_i.blue);
          if (want.color_valid) colors_o++;
        end
      end
      if (start_i && !busy_i) begin
        predict_result(cmd_i, want);
        expected_results.push_back(want);
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ----- verif/tb_video_controller_registers.sv -----
// ----------------------------------------------------------------------------
// tb_video_controller_registers
// drives directed and random command words into the video controller
// register block under three sender idle profiles; the result checker
// beside the block predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_video_controller_registers;
  import vcr_pkg::*;

  localparam int unsigned QuietLimit = 200000;
  localparam int unsigned DrainLimit = 2000;
  localparam int unsigned PhaseWords = 142;
  localparam logic [3:0]  OpSpareFirst = 4'd11;
  localparam logic [3:0]  OpSpareLast = 4'd15;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        result_valid_o;
  vcr_cmd_t    cmd = '0;
  vcr_result_t result;

  logic        taken = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned words_sent = 0;
  int unsigned sender_idle_pct = 0;
  int          errors;
  int          pending;
  int          colors;

  logic [7:0]  pool_row [8];
  logic [8:0]  pool_off [8];

  video_controller_registers uut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .cmd_i          (cmd),
    .result_valid_o,
    .result_o       (result)
  );

  vcr_result_checker result_check (
    .clk_i,
    .rst_ni,
    .start_i     (start),
    .busy_i      (busy),
    .cmd_i       (cmd),
    .res_valid_i (result_valid_o),
    .res_i       (result),
    .errors_o    (errors),
    .pending_o   (pending),
    .colors_o    (colors)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // acceptance flag and watchdog; the limit covers the clearing pass
  always @(posedge clk_i) begin
    taken <= start && !busy;
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("timeout after %0d quiet cycles", QuietLimit);
      $display("FAIL video_controller_registers");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic vcr_cmd_t make_word(input logic [3:0] op, input logic [8:0] off,
                                         input logic [7:0] data);
    vcr_cmd_t w;
    w.opcode = op;
    w.offset = off;
    w.write_data = data;
    w.row_select = 8'($urandom_range(255));
    w.beam_line = 9'($urandom_range(511));
    w.beam_x = 9'($urandom_range(511));
    return w;
  endfunction

  function automatic logic [7:0] ctrl_byte(input logic [3:0] rom, input logic en,
                                           input logic sel, input logic acc,
                                           input logic shown);
    return {rom, en, sel, acc, shown};
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic issue(input vcr_cmd_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd <= w;
    do @(negedge clk_i); while (!taken);
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic random_sequence();
    vcr_cmd_t   w;
    int unsigned k;
    logic [8:0] pal_off;
    logic [7:0] d;
    case ($urandom_range(9))
      0, 1: begin
        // video write then read back, often to a recently used address
        k = $urandom_range(7);
        w = make_word(OP_VRAM_WR, pool_off[k], 8'($urandom_range(255)));
        w.row_select = pool_row[k];
        issue(w);
        if ($urandom_range(3) == 0) issue(make_word(OP_VRAM_WR, 9'($urandom_range(511)),
                                                    8'($urandom_range(255))));
        w = make_word(OP_VRAM_RD, pool_off[k], 8'($urandom_range(255)));
        w.row_select = pool_row[k];
        issue(w);
      end
      2, 3: begin
        // palette pair, both bytes in either order, then a read
        pal_off = 9'($urandom_range(511));
        issue(make_word(OP_PAL_WR, pal_off, 8'($urandom_range(255))));
        issue(make_word(OP_PAL_WR, pal_off ^ 9'd1, 8'($urandom_range(255))));
        issue(make_word(OP_PAL_RD, pal_off ^ 9'($urandom_range(1)),
                        8'($urandom_range(255))));
      end
      4: begin
        d = 8'($urandom_range(255));
        if ($urandom_range(3) != 0) d[3] = 1'b1;
        issue(make_word(OP_CTRL_WR, 9'($urandom_range(511)), d));
      end
      5: begin
        issue(make_word($urandom_range(1) ? OP_BEAM : OP_COLLIDE, 9'($urandom_range(511)),
                        8'($urandom_range(255))));
        if ($urandom_range(1)) issue(make_word(OP_HPOS_RD, 9'($urandom_range(511)),
                                               8'($urandom_range(255))));
      end
      6: begin
        issue(make_word($urandom_range(1) ? OP_VBLANK : OP_IRQ_CLR,
                        9'($urandom_range(511)), 8'($urandom_range(255))));
      end
      7: begin
        case ($urandom_range(2))
          0: issue(make_word(OP_VPOS_RD, 9'($urandom_range(511)), 8'($urandom_range(255))));
          1: issue(make_word(OP_PAL_RD, 9'($urandom_range(511)), 8'($urandom_range(255))));
          default: issue(make_word(OP_VRAM_RD, 9'($urandom_range(511)),
                                   8'($urandom_range(255))));
        endcase
      end
      8: begin
        issue(make_word(4'($urandom_range(OpSpareLast)), 9'($urandom_range(511)),
                        8'($urandom_range(255))));
      end
      default: begin
        issue(make_word(4'($urandom_range(OpSpareLast, OpSpareFirst)),
                        9'($urandom_range(511)), 8'($urandom_range(255))));
      end
    endcase
  endtask

  initial begin
    vcr_cmd_t    w;
    int unsigned phase_end;
    int unsigned waited;

    for (int k = 0; k < 8; k++) begin
      pool_row[k] = 8'($urandom_range(255));
      pool_off[k] = 9'($urandom_range(511));
    end

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: address carry and wrap, palette extremes, banks, irq paths
    w = make_word(OP_VRAM_WR, 9'h1ff, 8'hff);
    w.row_select = 8'hff;
    issue(w);
    w = make_word(OP_VRAM_RD, 9'h1ff, 8'h00);
    w.row_select = 8'hff;
    issue(w);
    w = make_word(OP_VRAM_WR, 9'h000, 8'ha5);
    w.row_select = 8'h01;
    issue(w);
    w = make_word(OP_VRAM_RD, 9'h100, 8'h00);
    w.row_select = 8'h00;
    issue(w);
    w = make_word(OP_VRAM_RD, 9'h000, 8'h00);
    w.row_select = 8'h00;
    issue(w);
    issue(make_word(OP_PAL_WR, 9'h000, 8'hff));
    issue(make_word(OP_PAL_WR, 9'h001, 8'hff));
    issue(make_word(OP_PAL_RD, 9'h001, 8'h00));
    issue(make_word(OP_PAL_WR, 9'h1ff, 8'h80));
    issue(make_word(OP_CTRL_WR, 9'h000, ctrl_byte(4'hf, 1'b1, 1'b1, 1'b1, 1'b1)));
    issue(make_word(OP_PAL_WR, 9'h1fe, 8'h7c));
    issue(make_word(OP_PAL_RD, 9'h1fe, 8'h00));
    issue(make_word(OP_CTRL_WR, 9'h000, ctrl_byte(4'h0, 1'b1, 1'b0, 1'b1, 1'b0)));
    issue(make_word(OP_PAL_WR, 9'h002, 8'h55));
    w = make_word(OP_VPOS_RD, 9'h000, 8'h00);
    w.beam_line = 9'd511;
    issue(w);
    w.beam_line = 9'd255;
    issue(w);
    w.beam_line = 9'd254;
    issue(w);
    w = make_word(OP_COLLIDE, 9'h000, 8'h00);
    w.beam_x = 9'd511;
    issue(w);
    issue(make_word(OP_CTRL_WR, 9'h000, ctrl_byte(4'h3, 1'b0, 1'b0, 1'b1, 1'b0)));
    issue(make_word(OP_CTRL_WR, 9'h000, ctrl_byte(4'h3, 1'b1, 1'b0, 1'b1, 1'b0)));
    issue(make_word(OP_HPOS_RD, 9'h000, 8'h00));
    issue(make_word(OP_CTRL_WR, 9'h000, ctrl_byte(4'h9, 1'b1, 1'b1, 1'b0, 1'b0)));
    w = make_word(OP_BEAM, 9'h000, 8'h00);
    w.beam_x = 9'd0;
    issue(w);
    issue(make_word(OP_VBLANK, 9'h000, 8'h00));
    issue(make_word(OP_IRQ_CLR, 9'h000, 8'h00));
    issue(make_word(OP_HPOS_RD, 9'h000, 8'h00));
    issue(make_word(OpSpareFirst, 9'h1ff, 8'hff));
    issue(make_word(OpSpareLast, 9'h000, 8'h00));
    drain();

    // random sequences under three sender idle profiles
    sender_idle_pct = 31;
    phase_end = words_sent + PhaseWords;
    while (words_sent < phase_end) random_sequence();
    drain();
    sender_idle_pct = 88;
    phase_end = words_sent + PhaseWords;
    while (words_sent < phase_end) random_sequence();
    drain();
    sender_idle_pct = 0;
    phase_end = words_sent + PhaseWords;
    while (words_sent < phase_end) random_sequence();

    start <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);

    $display("covered %0d command words over three idle profiles, all opcodes and spares",
             words_sent);
    $display("%0d palette color reports checked, %0d results missing", colors, pending);
    if (errors == 0 && pending == 0) begin
      $display("PASS video_controller_registers");
    end else begin
      $display("FAIL video_controller_registers");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/vcr_pkg.sv
hdl/vcr_vram.sv
hdl/vcr_pram.sv
hdl/vcr_regs.sv
hdl/video_controller_registers.sv
hdl/vcr_checker.sv
verif/vcr_result_checker.sv
verif/tb_video_controller_registers.sv
